// File: rtl/s2sd_pkg.sv
package s2sd_pkg;

  localparam int FRAC_BITS = 8;
  localparam int PREC_BITS = 32;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DOT_W   = PROD_W + 1;
  localparam int X_W     = DOT_W + 2;
  localparam int MUL_W   = 64;
  localparam int WIDE_W  = 2 * MUL_W;
  localparam int DIV_W   = 104;
  localparam int THR_W   = 40;
  localparam int Q_W     = PREC_BITS + 1;
  localparam int PU_W    = DIFF_W + Q_W + 1;
  localparam int RAD_W   = 58;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int DIST_W  = 25;

  localparam int DIV_STEPS = Q_W;
  localparam int MUL_LAT   = 2;

  // pipeline stage numbers (register index after acceptance)
  localparam int ST_DIFF = 1;
  localparam int ST_PROD = 2;
  localparam int ST_DOT  = 3;
  localparam int ST_MUL  = ST_DOT + MUL_LAT;
  localparam int ST_DET  = ST_MUL + 1;
  localparam int ST_SEL  = ST_DET + 1;
  localparam int ST_TCL  = ST_SEL + 1;
  localparam int ST_SCL  = ST_TCL + 1;
  localparam int ST_ZF   = ST_SCL + 1;
  localparam int ST_DIV  = ST_ZF + DIV_STEPS;
  localparam int ST_PAR  = ST_DIV + 1;
  localparam int ST_PT   = ST_PAR + 1;
  localparam int ST_SQ   = ST_PT + MUL_LAT;
  localparam int ST_RAD  = ST_SQ + 1;
  localparam int ST_LAST = ST_RAD + ROOT_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [X_W-1:0]     x_t;
  typedef logic signed [MUL_W-1:0]   mul_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [DIV_W-1:0]   big_t;
  typedef logic        [DIV_W-1:0]   div_t;
  typedef logic        [THR_W-1:0]   thr_t;
  typedef logic        [Q_W-1:0]     quo_t;
  typedef logic signed [PU_W-1:0]    pu_t;
  typedef logic        [RAD_W-1:0]   rad_t;
  typedef logic        [ROOT_W-1:0]  root_t;
  typedef logic        [DIST_W-1:0]  dist_t;

  // epsilon 1e-8 at LSB 2^-(k*FRAC_BITS): smallest count not below it
  localparam longint unsigned EPS_DEN = 64'd100000000;
  localparam longint unsigned EPS2 = ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / EPS_DEN + 64'd1;
  localparam longint unsigned EPS4 = ((64'd1 << (4 * FRAC_BITS)) - 64'd1) / EPS_DEN + 64'd1;

  localparam thr_t  THR2    = thr_t'(EPS2);
  localparam thr_t  THR4    = thr_t'(EPS4);
  localparam thr_t  THR_ONE = thr_t'(1);
  localparam dist_t DIST_MAX = '1;

  typedef struct packed {
    big_t sn;
    big_t sd;
    big_t tn;
    big_t td;
    thr_t sthr;
    thr_t tthr;
  } frac_t;

  function automatic diff_t coord_sub(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

endpackage

// File: rtl/s2sd_in_if.sv
interface s2sd_in_if import s2sd_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t first_start_x;
  coord_t first_start_y;
  coord_t first_start_z;
  coord_t first_end_x;
  coord_t first_end_y;
  coord_t first_end_z;
  coord_t second_start_x;
  coord_t second_start_y;
  coord_t second_start_z;
  coord_t second_end_x;
  coord_t second_end_y;
  coord_t second_end_z;

  modport source (
    output valid, first_start_x, first_start_y, first_start_z,
    output first_end_x, first_end_y, first_end_z,
    output second_start_x, second_start_y, second_start_z,
    output second_end_x, second_end_y, second_end_z,
    input  ready
  );

  modport sink (
    input  valid, first_start_x, first_start_y, first_start_z,
    input  first_end_x, first_end_y, first_end_z,
    input  second_start_x, second_start_y, second_start_z,
    input  second_end_x, second_end_y, second_end_z,
    output ready
  );
endinterface

// File: rtl/s2sd_out_if.sv
interface s2sd_out_if import s2sd_pkg::*; ();
  logic  valid;
  logic  ready;
  dist_t min_distance;

  modport source (output valid, min_distance, input ready);
  modport sink   (input valid, min_distance, output ready);
endinterface

// File: rtl/s2sd_mul.sv
module s2sd_mul import s2sd_pkg::*; (
  input  logic clk,
  input  logic en,
  input  mul_t x,
  input  mul_t y,
  output wide_t p
);

  localparam int HW = MUL_W / 2;

  logic [MUL_W-1:0]  mx, my;
  logic [MUL_W-1:0]  pp_r [4];
  logic              neg_r;
  logic [WIDE_W-1:0] sum_nxt;
  wide_t             p_r;

  // magnitudes; -2^63 maps to 2^63, which fits unsigned
  assign mx = x[MUL_W-1] ? MUL_W'(-x) : MUL_W'(x);
  assign my = y[MUL_W-1] ? MUL_W'(-y) : MUL_W'(y);

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= mx[HW-1:0]     * my[HW-1:0];
      pp_r[1] <= mx[HW-1:0]     * my[MUL_W-1:HW];
      pp_r[2] <= mx[MUL_W-1:HW] * my[HW-1:0];
      pp_r[3] <= mx[MUL_W-1:HW] * my[MUL_W-1:HW];
      neg_r   <= x[MUL_W-1] ^ y[MUL_W-1];
    end
  end

  assign sum_nxt = WIDE_W'(pp_r[0])
                 + ((WIDE_W'(pp_r[1]) + WIDE_W'(pp_r[2])) << HW)
                 + (WIDE_W'(pp_r[3]) << MUL_W);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_r ? wide_t'(-sum_nxt) : wide_t'(sum_nxt);
    end
  end

  assign p = p_r;

endmodule

// File: rtl/s2sd_div.sv
module s2sd_div import s2sd_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t num,
  input  div_t den,
  output quo_t quo
);

  // restoring divider, one quotient bit per stage; num <= den on entry
  div_t rem_r [DIV_STEPS];
  div_t den_r [DIV_STEPS];
  quo_t q_r   [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    div_t rin;
    div_t dn;
    quo_t qin;
    logic ge;

    if (i == 0) begin : g_first
      assign rin = num;
      assign dn  = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = {rem_r[i-1][DIV_W-2:0], 1'b0};
      assign dn  = den_r[i-1];
      assign qin = q_r[i-1];
    end

    assign ge = (rin >= dn);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? (rin - dn) : rin;
        den_r[i] <= dn;
        q_r[i]   <= {qin[Q_W-2:0], ge};
      end
    end
  end

  assign quo = q_r[DIV_STEPS-1];

endmodule

// File: rtl/s2sd_sqrt.sv
module s2sd_sqrt import s2sd_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  rad_t  rad,
  output root_t root
);

  // digit-by-digit square root, one result bit per stage
  rad_t x_r    [ROOT_W];
  rad_t root_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    localparam rad_t BIT = rad_t'(1) << (RAD_W - 2 - 2 * i);
    rad_t xin;
    rad_t rin;
    rad_t trial;
    logic ge;

    if (i == 0) begin : g_first
      assign xin = rad;
      assign rin = '0;
    end else begin : g_next
      assign xin = x_r[i-1];
      assign rin = root_r[i-1];
    end

    assign trial = rin + BIT;
    assign ge    = (xin >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= ge ? (xin - trial) : xin;
        root_r[i] <= ge ? ((rin >> 1) + BIT) : (rin >> 1);
      end
    end
  end

  assign root = root_r[ROOT_W-1][ROOT_W-1:0];

endmodule

// File: rtl/segment_to_segment_distance.sv
// Shortest distance between two 3D segments, fully pipelined.
//
// in_ch carries one word per pair of segments: four endpoints, signed
// Q15.8. out_ch returns one word per input word, in order: min_distance,
// unsigned Q.8, rounded down and saturated at its full scale.
// Both channels use valid/ready; a word moves on a clock edge where both
// are high.
//
// Throughput: one word per cycle while the output buffer has room. The
// depth is set by the two restoring dividers for the segment parameters
// (33 stages) and the square-root pipeline (29 stages); the wide products
// use two-stage 32x32 partial-product multipliers.
//
// A two-word output buffer sits behind the pipe. The pipe advances while
// the buffer has room, so one word may wait at out_ch while another is
// accepted. With both slots full and out_ch stalled, in_ch.ready drops and
// the whole pipe holds; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and the buffer.
module segment_to_segment_distance import s2sd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  s2sd_in_if.sink    in_ch,
  s2sd_out_if.source out_ch
);

  localparam int IDX_A = 0;
  localparam int IDX_B = 1;
  localparam int IDX_C = 2;
  localparam int IDX_D = 3;
  localparam int IDX_E = 4;

  localparam int P_AC = 0;
  localparam int P_BB = 1;
  localparam int P_BE = 2;
  localparam int P_CD = 3;
  localparam int P_AE = 4;
  localparam int P_BD = 5;

  localparam int FIFO_DEPTH = 2;

  logic               en;
  logic [ST_LAST:1]   vld_r;

  // stage 1..ST_DIV: direction vectors u, v and offset w ride along
  diff_t u_dl_r [ST_DIFF:ST_DIV][3];
  diff_t v_dl_r [ST_DIFF:ST_DIV][3];
  diff_t w_dl_r [ST_DIFF:ST_DIV][3];

  prod_t uu_r [3];
  prod_t uv_r [3];
  prod_t vv_r [3];
  prod_t uw_r [3];
  prod_t vw_r [3];

  dot_t  dot_dl_r [ST_DOT:ST_TCL][5];

  mul_t  mx [6];
  mul_t  my [6];
  wide_t mp [6];

  big_t  det_r, sn0_r, tn0_r;

  frac_t sel_nxt, sel_r;
  frac_t tcl_nxt, tcl_r;
  frac_t scl_nxt, scl_r;
  x_t    x_nxt, x_r;
  logic  clamp_nxt, clamp_r;
  logic  par;

  div_t  snum_r, sden_r, tnum_r, tden_r;
  logic  zf_dl_r [ST_ZF:ST_DIV][2];
  quo_t  squo, tquo;
  quo_t  sc, tc;

  pu_t   pu_r [3];
  pu_t   pv_r [3];
  diff_t wp_r [3];
  mul_t  pt_r [3];
  wide_t sq_p [3];
  wide_t rsum;
  rad_t  rad_r;
  root_t root;
  dist_t dist_sat;

  dist_t       head_r, tail_r, head_nxt, tail_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  // ---------------------------------------------------------------
  // flow control: the whole pipe moves while the output buffer has room
  // ---------------------------------------------------------------
  assign en          = (cnt_r != 2'(FIFO_DEPTH));
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ST_LAST-1:1], in_ch.valid};
    end
  end

  // ---------------------------------------------------------------
  // stage 1: u = first_end - first_start, v = second_end - second_start,
  // w = first_start - second_start
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      u_dl_r[ST_DIFF][0] <= coord_sub(in_ch.first_end_x, in_ch.first_start_x);
      u_dl_r[ST_DIFF][1] <= coord_sub(in_ch.first_end_y, in_ch.first_start_y);
      u_dl_r[ST_DIFF][2] <= coord_sub(in_ch.first_end_z, in_ch.first_start_z);
      v_dl_r[ST_DIFF][0] <= coord_sub(in_ch.second_end_x, in_ch.second_start_x);
      v_dl_r[ST_DIFF][1] <= coord_sub(in_ch.second_end_y, in_ch.second_start_y);
      v_dl_r[ST_DIFF][2] <= coord_sub(in_ch.second_end_z, in_ch.second_start_z);
      w_dl_r[ST_DIFF][0] <= coord_sub(in_ch.first_start_x, in_ch.second_start_x);
      w_dl_r[ST_DIFF][1] <= coord_sub(in_ch.first_start_y, in_ch.second_start_y);
      w_dl_r[ST_DIFF][2] <= coord_sub(in_ch.first_start_z, in_ch.second_start_z);
      for (int k = ST_DIFF + 1; k <= ST_DIV; k++) begin
        u_dl_r[k] <= u_dl_r[k-1];
        v_dl_r[k] <= v_dl_r[k-1];
        w_dl_r[k] <= w_dl_r[k-1];
      end
    end
  end

  // stage 2: per-axis products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        uu_r[i] <= u_dl_r[ST_DIFF][i] * u_dl_r[ST_DIFF][i];
        uv_r[i] <= u_dl_r[ST_DIFF][i] * v_dl_r[ST_DIFF][i];
        vv_r[i] <= v_dl_r[ST_DIFF][i] * v_dl_r[ST_DIFF][i];
        uw_r[i] <= u_dl_r[ST_DIFF][i] * w_dl_r[ST_DIFF][i];
        vw_r[i] <= v_dl_r[ST_DIFF][i] * w_dl_r[ST_DIFF][i];
      end
    end
  end

  // stage 3: dot products a=u.u b=u.v c=v.v d=u.w e=v.w, kept to stage 8
  always_ff @(posedge clk) begin
    if (en) begin
      dot_dl_r[ST_DOT][IDX_A] <= dot_t'(uu_r[0]) + dot_t'(uu_r[1]) + dot_t'(uu_r[2]);
      dot_dl_r[ST_DOT][IDX_B] <= dot_t'(uv_r[0]) + dot_t'(uv_r[1]) + dot_t'(uv_r[2]);
      dot_dl_r[ST_DOT][IDX_C] <= dot_t'(vv_r[0]) + dot_t'(vv_r[1]) + dot_t'(vv_r[2]);
      dot_dl_r[ST_DOT][IDX_D] <= dot_t'(uw_r[0]) + dot_t'(uw_r[1]) + dot_t'(uw_r[2]);
      dot_dl_r[ST_DOT][IDX_E] <= dot_t'(vw_r[0]) + dot_t'(vw_r[1]) + dot_t'(vw_r[2]);
      for (int k = ST_DOT + 1; k <= ST_TCL; k++) begin
        dot_dl_r[k] <= dot_dl_r[k-1];
      end
    end
  end

  // stages 4-5: the six wide products for determinant and numerators
  assign mx[P_AC] = mul_t'(dot_dl_r[ST_DOT][IDX_A]);
  assign my[P_AC] = mul_t'(dot_dl_r[ST_DOT][IDX_C]);
  assign mx[P_BB] = mul_t'(dot_dl_r[ST_DOT][IDX_B]);
  assign my[P_BB] = mul_t'(dot_dl_r[ST_DOT][IDX_B]);
  assign mx[P_BE] = mul_t'(dot_dl_r[ST_DOT][IDX_B]);
  assign my[P_BE] = mul_t'(dot_dl_r[ST_DOT][IDX_E]);
  assign mx[P_CD] = mul_t'(dot_dl_r[ST_DOT][IDX_C]);
  assign my[P_CD] = mul_t'(dot_dl_r[ST_DOT][IDX_D]);
  assign mx[P_AE] = mul_t'(dot_dl_r[ST_DOT][IDX_A]);
  assign my[P_AE] = mul_t'(dot_dl_r[ST_DOT][IDX_E]);
  assign mx[P_BD] = mul_t'(dot_dl_r[ST_DOT][IDX_B]);
  assign my[P_BD] = mul_t'(dot_dl_r[ST_DOT][IDX_D]);

  for (genvar g = 0; g < 6; g++) begin : g_dmul
    s2sd_mul u_mul (
      .clk (clk),
      .en  (en),
      .x   (mx[g]),
      .y   (my[g]),
      .p   (mp[g])
    );
  end

  // stage 6: D = ac - bb, s numerator be - cd, t numerator ae - bd
  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= big_t'(mp[P_AC] - mp[P_BB]);
      sn0_r <= big_t'(mp[P_BE] - mp[P_CD]);
      tn0_r <= big_t'(mp[P_AE] - mp[P_BD]);
    end
  end

  // stage 7: parallel branch, then s clamped against the ends of [0,1]
  assign par = (det_r < big_t'(THR4));

  always_comb begin
    sel_nxt.sn   = sn0_r;
    sel_nxt.sd   = det_r;
    sel_nxt.tn   = tn0_r;
    sel_nxt.td   = det_r;
    sel_nxt.sthr = THR4;
    sel_nxt.tthr = THR4;
    if (par) begin
      sel_nxt.sn   = '0;
      sel_nxt.sd   = big_t'(1);
      sel_nxt.sthr = THR_ONE;
      sel_nxt.tn   = big_t'(dot_dl_r[ST_DET][IDX_E]);
      sel_nxt.td   = big_t'(dot_dl_r[ST_DET][IDX_C]);
      sel_nxt.tthr = THR2;
    end else if (sn0_r < 0) begin
      sel_nxt.sn   = '0;
      sel_nxt.tn   = big_t'(dot_dl_r[ST_DET][IDX_E]);
      sel_nxt.td   = big_t'(dot_dl_r[ST_DET][IDX_C]);
      sel_nxt.tthr = THR2;
    end else if (det_r < sn0_r) begin
      sel_nxt.sn   = det_r;
      sel_nxt.tn   = big_t'(dot_dl_r[ST_DET][IDX_E]) + big_t'(dot_dl_r[ST_DET][IDX_B]);
      sel_nxt.td   = big_t'(dot_dl_r[ST_DET][IDX_C]);
      sel_nxt.tthr = THR2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_r <= sel_nxt;
    end
  end

  // stage 8: clamp t; a clamped t moves s to x / a
  always_comb begin
    tcl_nxt   = sel_r;
    clamp_nxt = 1'b0;
    x_nxt     = '0;
    if (sel_r.tn < 0) begin
      tcl_nxt.tn = '0;
      x_nxt      = x_t'(0) - x_t'(dot_dl_r[ST_SEL][IDX_D]);
      clamp_nxt  = 1'b1;
    end else if (sel_r.td < sel_r.tn) begin
      tcl_nxt.tn = sel_r.td;
      x_nxt      = x_t'(dot_dl_r[ST_SEL][IDX_B]) - x_t'(dot_dl_r[ST_SEL][IDX_D]);
      clamp_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tcl_r   <= tcl_nxt;
      x_r     <= x_nxt;
      clamp_r <= clamp_nxt;
    end
  end

  // stage 9: recompute s after a t clamp
  always_comb begin
    scl_nxt = tcl_r;
    if (clamp_r) begin
      if (x_r < 0) begin
        scl_nxt.sn = '0;
      end else if (x_r > x_t'(dot_dl_r[ST_TCL][IDX_A])) begin
        scl_nxt.sn = tcl_r.sd;
      end else begin
        scl_nxt.sn   = big_t'(x_r);
        scl_nxt.sd   = big_t'(dot_dl_r[ST_TCL][IDX_A]);
        scl_nxt.sthr = THR2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scl_r <= scl_nxt;
    end
  end

  // stage 10: tiny numerators give a zero parameter
  always_ff @(posedge clk) begin
    if (en) begin
      snum_r         <= div_t'(scl_r.sn);
      sden_r         <= div_t'(scl_r.sd);
      tnum_r         <= div_t'(scl_r.tn);
      tden_r         <= div_t'(scl_r.td);
      zf_dl_r[ST_ZF][0] <= (scl_r.sn < big_t'(scl_r.sthr));
      zf_dl_r[ST_ZF][1] <= (scl_r.tn < big_t'(scl_r.tthr));
      for (int k = ST_ZF + 1; k <= ST_DIV; k++) begin
        zf_dl_r[k] <= zf_dl_r[k-1];
      end
    end
  end

  // stages 11..ST_DIV: sc, tc as 1.32 fractions
  s2sd_div u_sdiv (
    .clk (clk),
    .en  (en),
    .num (snum_r),
    .den (sden_r),
    .quo (squo)
  );

  s2sd_div u_tdiv (
    .clk (clk),
    .en  (en),
    .num (tnum_r),
    .den (tden_r),
    .quo (tquo)
  );

  assign sc = zf_dl_r[ST_DIV][0] ? '0 : squo;
  assign tc = zf_dl_r[ST_DIV][1] ? '0 : tquo;

  // closest-point difference w + u*sc - v*tc at LSB 2^-(F+32)
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pu_r[i] <= u_dl_r[ST_DIV][i] * $signed({1'b0, sc});
        pv_r[i] <= v_dl_r[ST_DIV][i] * $signed({1'b0, tc});
        wp_r[i] <= w_dl_r[ST_DIV][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pt_r[i] <= (mul_t'(wp_r[i]) <<< PREC_BITS) + mul_t'(pu_r[i]) - mul_t'(pv_r[i]);
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_sq
    s2sd_mul u_sq (
      .clk (clk),
      .en  (en),
      .x   (pt_r[g]),
      .y   (pt_r[g]),
      .p   (sq_p[g])
    );
  end

  // floor(sqrt(S)) >> 32 == floor(sqrt(S >> 64)), so only the top bits matter
  assign rsum = sq_p[0] + sq_p[1] + sq_p[2];

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= rsum[MUL_W +: RAD_W];
    end
  end

  s2sd_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad_r),
    .root (root)
  );

  assign dist_sat = (root[ROOT_W-1:DIST_W] != '0) ? DIST_MAX : root[DIST_W-1:0];

  // ---------------------------------------------------------------
  // two-word output buffer
  // ---------------------------------------------------------------
  assign push = en && vld_r[ST_LAST];
  assign pop  = (cnt_r != 2'd0) && out_ch.ready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          head_nxt = dist_sat;
        end else begin
          tail_nxt = dist_sat;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        head_nxt = tail_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          head_nxt = dist_sat;
        end else begin
          head_nxt = tail_r;
          tail_nxt = dist_sat;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.min_distance = head_r;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(FIFO_DEPTH))
    else $error("output buffer over depth");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipe valid bits moved during stall");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (cnt_r == 2'd0 && vld_r == '0))
    else $error("reset did not clear pipe");

endmodule

// File: verif/tb_segment_to_segment_distance.sv
`timescale 1ns / 100ps

module tb_segment_to_segment_distance import s2sd_pkg::*;;

  typedef logic signed [127:0] s128_t;
  typedef logic        [127:0] u128_t;
  // endpoint order: first start xyz, first end xyz, second start xyz, second end xyz
  typedef coord_t [11:0] seg_pair_t;

  localparam int STALL_LEN = 300;
  localparam int WATCHDOG  = 5000;
  localparam int DRAIN     = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  s2sd_in_if  in_ch ();
  s2sd_out_if out_ch ();

  segment_to_segment_distance u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #6 clk = ~clk;

  dist_t dist_q[$];      // distances still owed by the block
  int    send_idle_pct;  // sender gap chance, percent
  int    recv_idle_pct;  // receiver stall chance, percent
  int    stall_reqs;     // long receiver hold-offs asked for
  int    mismatches;
  int    quiet_cycles;
  bit    timed_out;

  // ---------------------------------------------------------------------
  // Distance predictor
  // ---------------------------------------------------------------------

  // floor(num * 2^32 / den), 0 <= num <= den, den > 0
  function automatic logic [63:0] seg_param(s128_t num, s128_t den);
    logic [159:0] n, q;
    n = {32'd0, num};
    n = n << PREC_BITS;
    q = n / {32'd0, den};
    return q[63:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(u128_t x);
    u128_t root, bitv, t;
    root = '0;
    bitv = u128_t'(1) << 126;
    for (int i = 0; i < 64; i++) begin
      t = root + bitv;
      if (x >= t) begin
        x    = x - t;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[63:0];
  endfunction

  function automatic dist_t predict_distance(seg_pair_t pt);
    longint p[12], u[3], v[3], w[3];
    longint a, b, c, d, e, x;
    s128_t  det, sn, sd, sthr, tn, td, tthr, t2, t4, pq, m;
    u128_t  sum;
    logic [63:0] sc, tc, r;
    bit clamp_t;
    for (int i = 0; i < 12; i++) p[i] = longint'(pt[i]);
    a = 0; b = 0; c = 0; d = 0; e = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = p[3+i] - p[i];
      v[i] = p[9+i] - p[6+i];
      w[i] = p[i] - p[6+i];
      a += u[i] * u[i];
      b += u[i] * v[i];
      c += v[i] * v[i];
      d += u[i] * w[i];
      e += v[i] * w[i];
    end
    t2  = s128_t'(EPS2);
    t4  = s128_t'(EPS4);
    det = s128_t'(a) * s128_t'(c) - s128_t'(b) * s128_t'(b);

    if (det < t4) begin
      // near parallel: pin sc at 0, project onto second segment
      sn = 0; sd = 1; sthr = 1;
      tn = s128_t'(e); td = s128_t'(c); tthr = t2;
    end else begin
      sn = s128_t'(b) * s128_t'(e) - s128_t'(c) * s128_t'(d);
      tn = s128_t'(a) * s128_t'(e) - s128_t'(b) * s128_t'(d);
      sd = det; td = det; sthr = t4; tthr = t4;
      if (sn < 0) begin
        sn = 0; tn = s128_t'(e); td = s128_t'(c); tthr = t2;
      end else if (sn > sd) begin
        sn = sd; tn = s128_t'(e + b); td = s128_t'(c); tthr = t2;
      end
    end

    x = 0;
    clamp_t = 1'b0;
    if (tn < 0) begin
      tn = 0; x = -d; clamp_t = 1'b1;
    end else if (tn > td) begin
      tn = td; x = b - d; clamp_t = 1'b1;
    end
    if (clamp_t) begin
      if (x < 0) sn = 0;
      else if (x > a) sn = sd;
      else begin
        sn = s128_t'(x); sd = s128_t'(a); sthr = t2;
      end
    end

    // tiny numerators snap to zero, which also covers zero-length segments
    sc = (sn < sthr) ? 64'd0 : seg_param(sn, sd);
    tc = (tn < tthr) ? 64'd0 : seg_param(tn, td);

    sum = '0;
    for (int i = 0; i < 3; i++) begin
      pq = (s128_t'(w[i]) <<< PREC_BITS) + s128_t'(u[i]) * s128_t'({64'd0, sc})
         - s128_t'(v[i]) * s128_t'({64'd0, tc});
      m = (pq < 0) ? -pq : pq;
      sum += u128_t'(m) * u128_t'(m);
    end
    r = floor_sqrt(sum) >> PREC_BITS;
    return (r > 64'(DIST_MAX)) ? DIST_MAX : dist_t'(r);
  endfunction

  // ---------------------------------------------------------------------
  // Sender: one word per call, random gaps ahead of it
  // ---------------------------------------------------------------------
  task automatic send_pair(seg_pair_t pt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.first_start_x  <= pt[0];
    in_ch.first_start_y  <= pt[1];
    in_ch.first_start_z  <= pt[2];
    in_ch.first_end_x    <= pt[3];
    in_ch.first_end_y    <= pt[4];
    in_ch.first_end_z    <= pt[5];
    in_ch.second_start_x <= pt[6];
    in_ch.second_start_y <= pt[7];
    in_ch.second_start_z <= pt[8];
    in_ch.second_end_x   <= pt[9];
    in_ch.second_end_y   <= pt[10];
    in_ch.second_end_z   <= pt[11];
    in_ch.valid          <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    dist_q.push_back(predict_distance(pt));
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus long hold-offs on request
  // ---------------------------------------------------------------------
  initial begin
    int stalls_done;
    int hold;
    stalls_done = 0;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && stalls_done != stall_reqs) begin
        stalls_done++;
        hold = STALL_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    dist_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (dist_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: min_distance=%0d", out_ch.min_distance);
      end else begin
        want = dist_q.pop_front();
        if (out_ch.min_distance !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("min_distance mismatch: expected %0d, got %0d",
                     want, out_ch.min_distance);
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_segment_to_segment_distance: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic coord_t near_coord(int span);
    return coord_t'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic seg_pair_t make_pair(int kind);
    seg_pair_t pt;
    int span, k;
    span = ($urandom_range(3) == 0) ? 2000000 : 3000;
    for (int i = 0; i < 12; i++) pt[i] = near_coord(span);
    case (kind)
      0: begin   // full-range noise, every bit moves
        for (int i = 0; i < 12; i++) pt[i] = coord_t'($urandom);
      end
      1: begin   // second parallel to first, scaled and shifted
        k = int'($urandom_range(6)) - 3;
        for (int i = 0; i < 3; i++)
          pt[9+i] = coord_t'(longint'(pt[6+i]) + k * (longint'(pt[3+i]) - longint'(pt[i])));
      end
      2: begin   // first segment is a point
        for (int i = 0; i < 3; i++) pt[3+i] = pt[i];
      end
      3: begin   // second segment is a point
        for (int i = 0; i < 3; i++) pt[9+i] = pt[6+i];
      end
      4: begin   // segments share an endpoint
        for (int i = 0; i < 3; i++) pt[6+i] = pt[$urandom_range(1) * 3 + i];
      end
      5: begin   // nearly parallel: tiny perturbation of a parallel pair
        for (int i = 0; i < 3; i++)
          pt[9+i] = coord_t'(longint'(pt[6+i]) + longint'(pt[3+i]) - longint'(pt[i])
                             + int'($urandom_range(2)) - 1);
      end
      default: ;  // generic skew pair
    endcase
    return pt;
  endfunction

  function automatic seg_pair_t pair_of(int fx0, int fy0, int fz0, int fx1, int fy1, int fz1,
                                        int sx0, int sy0, int sz0, int sx1, int sy1, int sz1);
    seg_pair_t pt;
    pt[0] = coord_t'(fx0); pt[1]  = coord_t'(fy0); pt[2]  = coord_t'(fz0);
    pt[3] = coord_t'(fx1); pt[4]  = coord_t'(fy1); pt[5]  = coord_t'(fz1);
    pt[6] = coord_t'(sx0); pt[7]  = coord_t'(sy0); pt[8]  = coord_t'(sz0);
    pt[9] = coord_t'(sx1); pt[10] = coord_t'(sy1); pt[11] = coord_t'(sz1);
    return pt;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  localparam int MX = 8388607;
  localparam int MN = -8388608;

  task automatic test_directed();
    seg_pair_t pt;
    // all zero: both segments collapse onto one point
    send_pair(pair_of(0,0,0, 0,0,0, 0,0,0, 0,0,0));
    // opposite corners of the coordinate box
    send_pair(pair_of(MN,MN,MN, MN,MN,MN, MX,MX,MX, MX,MX,MX));
    send_pair(pair_of(MN,MN,MN, MX,MX,MX, MX,MN,MX, MN,MX,MN));
    send_pair(pair_of(MX,MN,MN, MX,MN,MN, MN,MX,MX, MN,MX,MX));
    send_pair(pair_of(MN,0,0, MX,0,0, 0,MN,MX, 0,MX,MX));
    // perpendicular crossing, distance 1.0
    send_pair(pair_of(-256,0,0, 256,0,0, 0,-256,256, 0,256,256));
    // parallel and collinear overlapping
    send_pair(pair_of(0,0,0, 1024,0,0, 0,512,0, 1024,512,0));
    send_pair(pair_of(0,0,0, 1024,0,0, 512,0,0, 2048,0,0));
    // parallel, second reversed and past the end
    send_pair(pair_of(0,0,0, 1024,0,0, 4096,300,0, 2048,300,0));
    // first segment a point, second a line
    send_pair(pair_of(100,200,300, 100,200,300, -500,0,0, 500,0,0));
    // second a point
    send_pair(pair_of(-500,0,0, 500,0,0, 0,700,-100, 0,700,-100));
    // clamps: sc below 0, sc above 1, tc below 0, tc above 1
    send_pair(pair_of(256,0,0, 1024,0,0, 0,-256,512, 0,256,512));
    send_pair(pair_of(-1024,0,0, -256,0,0, 0,-256,512, 0,256,512));
    send_pair(pair_of(-256,0,0, 256,0,0, 0,256,512, 0,1024,512));
    send_pair(pair_of(-256,0,0, 256,0,0, 0,-1024,512, 0,-256,512));
    // both clamped, corner to corner
    send_pair(pair_of(256,0,0, 1024,0,0, 0,300,0, 0,1024,0));
    // shared endpoint
    send_pair(pair_of(10,20,30, 900,-40,70, 10,20,30, -300,800,5));
    // unit steps: smallest nonzero lengths
    send_pair(pair_of(0,0,0, 1,0,0, 0,1,0, 0,1,1));
    send_pair(pair_of(0,0,0, 1,1,1, 1,0,0, 2,1,1));
    // huge segments, nearly parallel
    send_pair(pair_of(MN,MN,0, MX,MX,0, MN,MN,1, MX,MX-1,1));
    for (int i = 0; i < 4; i++) begin
      pt = make_pair(5);
      send_pair(pt);
    end
  endtask

  task automatic test_random(int count);
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      send_pair(make_pair(kind > 6 ? 6 : kind));
    end
  endtask

  // receiver holds off while the sender keeps the input busy
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_reqs <= stall_reqs + 1;
    test_random(200);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    mismatches    = 0;
    quiet_cycles  = 0;
    timed_out     = 1'b0;
    stall_reqs    = 0;
    send_idle_pct = 28;
    recv_idle_pct = 74;
    in_ch.valid          = 1'b0;
    in_ch.first_start_x  = '0;
    in_ch.first_start_y  = '0;
    in_ch.first_start_z  = '0;
    in_ch.first_end_x    = '0;
    in_ch.first_end_y    = '0;
    in_ch.first_end_z    = '0;
    in_ch.second_start_x = '0;
    in_ch.second_start_y = '0;
    in_ch.second_start_z = '0;
    in_ch.second_end_x   = '0;
    in_ch.second_end_y   = '0;
    in_ch.second_end_z   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(180);
    send_idle_pct = 74;
    recv_idle_pct = 28;
    test_random(180);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(40);
    test_backpressure();

    drain();
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && dist_q.size() == 0)
      $display("tb_segment_to_segment_distance: clean");
    else
      $display("tb_segment_to_segment_distance: errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/s2sd_pkg.sv
rtl/s2sd_in_if.sv
rtl/s2sd_out_if.sv
rtl/s2sd_mul.sv
rtl/s2sd_div.sv
rtl/s2sd_sqrt.sv
rtl/segment_to_segment_distance.sv
verif/tb_segment_to_segment_distance.sv
